/* rtl/dsti_pkg.sv */
// ----------------------------------------------------------------------------
// Device slot table insert package
// Shared types, constants and helpers for the device slot table insert core.
// ----------------------------------------------------------------------------
package dsti_pkg;

	localparam int SLOTS  = 8;                   // power of two, 2 .. 8
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	localparam logic [15:0] SEED_RESET = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [2:0]  DUP_MAX    = 3'd7;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_STATUS = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_MERGED  = 3'd0,
		OUT_EMPTY   = 3'd1,
		OUT_OFFLINE = 3'd2,
		OUT_RANDOM  = 3'd3,
		OUT_STATUS  = 3'd4
	} outcome_t;

	typedef struct packed {
		cmd_t        command;
		logic [47:0] device_id;
		logic [31:0] ip_address;
		logic        entry_online;
		logic [2:0]  target_slot;
	} req_t;

	typedef struct packed {
		logic [2:0] slot;
		outcome_t   outcome;
		logic [2:0] duplicates_cleared;
	} rsp_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen;
		outcome_t          outcome;
		logic [2:0]        dups;
		logic [SLOTS-1:0]  clear;
		logic              advance;
	} pick_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		logic [15:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage

/* rtl/dsti_pick.sv */
// ----------------------------------------------------------------------------
// Slot picker
// Chooses the slot for an insert: first match, first empty, first offline or
// the LFSR victim, and marks further matches for clearing.
// ----------------------------------------------------------------------------
module dsti_pick
	import dsti_pkg::*;
(
	input  logic [SLOTS-1:0]  slot_valid,
	input  logic [SLOTS-1:0]  slot_online,
	input  logic [SLOTS-1:0]  match,
	input  logic [SLOT_W-1:0] victim,
	output pick_t             pick
);

	logic [SLOTS-1:0]  hit;
	logic [SLOTS-1:0]  empty;
	logic [SLOTS-1:0]  offline;
	logic [SLOTS-1:0]  first_hit;
	logic [SLOT_W-1:0] hit_idx;
	logic [SLOT_W-1:0] empty_idx;
	logic [SLOT_W-1:0] offline_idx;
	logic              hit_any;
	logic              empty_any;
	logic              offline_any;
	logic [CNT_W-1:0]  dup_cnt;

	assign hit     = match & slot_valid;
	assign empty   = ~slot_valid;
	assign offline = slot_valid & ~match & ~slot_online;

	always_comb begin
		hit_any     = 1'b0;
		empty_any   = 1'b0;
		offline_any = 1'b0;
		hit_idx     = '0;
		empty_idx   = '0;
		offline_idx = '0;
		first_hit   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_any   = 1'b1;
				hit_idx   = SLOT_W'(i);
				first_hit = '0;
				first_hit[i] = 1'b1;
			end
			if (empty[i]) begin
				empty_any = 1'b1;
				empty_idx = SLOT_W'(i);
			end
			if (offline[i]) begin
				offline_any = 1'b1;
				offline_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		dup_cnt = '0;
		for (int i = 0; i < SLOTS; i++) begin
			dup_cnt = dup_cnt + CNT_W'(hit[i] & ~first_hit[i]);
		end
	end

	always_comb begin
		pick.clear   = hit & ~first_hit;
		pick.advance = 1'b0;
		if (32'(dup_cnt) > 32'(DUP_MAX)) begin
			pick.dups = DUP_MAX;
		end else begin
			pick.dups = 3'(dup_cnt);
		end
		if (hit_any) begin
			pick.chosen  = hit_idx;
			pick.outcome = OUT_MERGED;
		end else if (empty_any) begin
			pick.chosen  = empty_idx;
			pick.outcome = OUT_EMPTY;
		end else if (offline_any) begin
			pick.chosen  = offline_idx;
			pick.outcome = OUT_OFFLINE;
		end else begin
			pick.chosen  = victim;
			pick.outcome = OUT_RANDOM;
			pick.advance = 1'b1;
		end
	end

endmodule

/* rtl/device_slot_table_insert_core.sv */
// ----------------------------------------------------------------------------
// Device slot table insert core
// A word is registered into valid_s1/req_s1, then its result into done/rsp; one word accepted every cycle.
// busy is held low: the table is read and written in the execute stage.
// Throughput is one word per cycle, as the slot compare is combinational.
// Reset empties the table, clears online flags and loads the LFSR seed.
// done is a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module device_slot_table_insert_core
	import dsti_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        seed_we,
	input  logic [15:0] seed_wdata
);

	logic              valid_s1;
	req_t              req_s1;
	logic [SLOTS-1:0]  slot_valid_q;
	logic [SLOTS-1:0]  slot_online_q;
	logic [47:0]       slot_id_q [SLOTS];
	logic [31:0]       slot_addr_q [SLOTS];
	logic [15:0]       lfsr_q;
	logic [SLOTS-1:0]  match;
	pick_t             pick;
	logic              ins;
	logic              sts;
	logic              sts_in_range;
	logic [SLOT_W-1:0] sts_idx;
	logic              done_q;
	rsp_t              rsp_q;

	assign busy = 1'b0;
	assign done = done_q;
	assign rsp  = rsp_q;

	assign ins          = valid_s1 && (req_s1.command == CMD_INSERT);
	assign sts          = valid_s1 && (req_s1.command == CMD_STATUS);
	assign sts_in_range = 32'(req_s1.target_slot) < SLOTS;
	assign sts_idx      = SLOT_W'(req_s1.target_slot);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (slot_id_q[i] == req_s1.device_id) ||
				(slot_addr_q[i] == req_s1.ip_address);
		end
	end

	dsti_pick u_pick (
		.slot_valid  (slot_valid_q),
		.slot_online (slot_online_q),
		.match       (match),
		.victim      (lfsr_q[SLOT_W-1:0]),
		.pick        (pick)
	);

	// capture word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// table flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q  <= '0;
			slot_online_q <= '0;
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (ins) begin
					if (pick.clear[i]) begin
						slot_valid_q[i]  <= 1'b0;
						slot_online_q[i] <= 1'b0;
					end
					if (pick.chosen == SLOT_W'(i)) begin
						slot_valid_q[i]  <= 1'b1;
						slot_online_q[i] <= req_s1.entry_online;
					end
				end else if (sts && sts_in_range && (sts_idx == SLOT_W'(i))) begin
					slot_online_q[i] <= req_s1.entry_online;
				end
			end
		end
	end

	// table payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (ins && (pick.chosen == SLOT_W'(i))) begin
				slot_id_q[i]   <= req_s1.device_id;
				slot_addr_q[i] <= req_s1.ip_address;
			end
		end
	end

	// victim LFSR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= SEED_RESET;
		end else if (seed_we) begin
			lfsr_q <= (seed_wdata == 16'd0) ? SEED_RESET : seed_wdata;
		end else if (ins && pick.advance) begin
			lfsr_q <= lfsr_next(lfsr_q);
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			rsp_q.slot               <= 3'(pick.chosen);
			rsp_q.outcome            <= pick.outcome;
			rsp_q.duplicates_cleared <= pick.dups;
		end else if (sts) begin
			rsp_q.slot               <= req_s1.target_slot;
			rsp_q.outcome            <= OUT_STATUS;
			rsp_q.duplicates_cleared <= 3'd0;
		end
	end

`ifndef ASSERT_OFF
	a_done_follows_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("done without a word in execute");

	a_insert_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ins |=> slot_valid_q[$past(pick.chosen)])
		else $error("chosen slot not valid after insert");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("victim LFSR locked at zero");

	a_merge_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		(ins && ((match & slot_valid_q) != '0)) |-> (pick.outcome == OUT_MERGED))
		else $error("match present but no merge");
`endif

endmodule
